FILE: sv/hdt_pkg.sv
package hdt_pkg;

    localparam int NODE_COUNT    = 512;
    localparam int BITS_PER_BYTE = 8;
    localparam int NODE_AW       = $clog2(NODE_COUNT);
    localparam int BIT_CW        = $clog2(BITS_PER_BYTE);
    localparam int FIELD_IW      = 9;
    localparam int CFG_IW        = 2;

    typedef logic [NODE_AW-1:0]  node_idx_t;
    typedef logic [FIELD_IW-1:0] field_idx_t;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IW-1:0] {
        CFG_ROOT_NODE        = 2'd0,
        CFG_SYMBOLS_EXPECTED = 2'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        field_idx_t  left;
        field_idx_t  right;
        logic        leaf;
        logic [7:0]  sym;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    function automatic node_idx_t wrap_index(field_idx_t v);
        return node_idx_t'(v);
    endfunction

    function automatic node_idx_t child_of(node_t e, logic b);
        return b ? wrap_index(e.right) : wrap_index(e.left);
    endfunction

endpackage

FILE: sv/hdt_if.sv
interface hdt_item_if;
    import hdt_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       command;
    field_idx_t       node_index;
    field_idx_t       node_left;
    field_idx_t       node_right;
    logic             node_is_leaf;
    logic [7:0]       node_symbol;
    logic [7:0]       data_byte;

    modport source (
        output valid, command, node_index, node_left, node_right,
               node_is_leaf, node_symbol, data_byte,
        input  ready
    );
    modport sink (
        input  valid, command, node_index, node_left, node_right,
               node_is_leaf, node_symbol, data_byte,
        output ready
    );
endinterface

interface hdt_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_of_item;
    logic       stream_done;

    modport source (
        output valid, symbol, last_of_item, stream_done,
        input  ready
    );
    modport sink (
        input  valid, symbol, last_of_item, stream_done,
        output ready
    );
endinterface

interface hdt_cfg_if;
    import hdt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [31:0]       data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: sv/hdt_ram.sv
module hdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/huffman_tree_table_decoder_unit.sv
// data byte: accepted in idle, the current node is fetched, then one node table read per bit
// until the byte ends or the expected count is met, then the final symbol is released
// the per-bit node table read loop sets the rate; a stalled output stretches it
// load, start and unknown items are taken in idle and give no result
// reset clears the walk position, symbol count, configuration registers and output; the node
// table is undefined until loaded and gets no clearing pass
module huffman_tree_table_decoder_unit (
    input  logic          clk,
    input  logic          rst_n,
    hdt_item_if.sink      cmd_bus,
    hdt_result_if.source  sym_bus,
    hdt_cfg_if.sink       cfg_bus
);
    import hdt_pkg::*;

    state_t              state_reg, state_next;
    field_idx_t          root_reg, root_next;
    logic [31:0]         expected_reg, expected_next;
    node_idx_t           cur_node_reg, cur_node_next;
    logic [31:0]         emitted_reg, emitted_next;
    logic [7:0]          byte_reg, byte_next;
    logic [BIT_CW-1:0]   bit_cnt_reg, bit_cnt_next;
    node_idx_t           addr_reg, addr_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [7:0]          pend_sym_reg, pend_sym_next;
    logic                pend_done_reg, pend_done_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_sym_reg, out_sym_next;
    logic                out_last_reg, out_last_next;
    logic                out_done_reg, out_done_next;

    node_t               walk_rdata;
    node_t               root_rdata;
    node_t               load_entry;
    node_t               walk_entry;
    node_idx_t           walk_node;
    node_idx_t           rd_addr;
    logic                tbl_we;
    node_idx_t           tbl_waddr;
    logic                cmd_acc;
    logic                finished;
    logic                leaf_hit;
    logic                out_free;
    logic                stall;
    logic                walk_last;
    logic                push_new;
    logic                move_pend;
    logic [31:0]         emitted_inc;
    logic [BIT_CW-1:0]   bit_nxt;

    // two copies of the table: one follows the walk, one reads the root entry
    hdt_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_walk_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (load_entry),
        .raddr (rd_addr),
        .rdata (walk_rdata)
    );

    hdt_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_root_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (load_entry),
        .raddr (wrap_index(root_reg)),
        .rdata (root_rdata)
    );

    assign cmd_bus.ready = (state_reg == ST_IDLE);
    assign cfg_bus.ready = 1'b1;
    assign cmd_acc       = cmd_bus.valid && cmd_bus.ready;

    assign load_entry.left  = cmd_bus.node_left;
    assign load_entry.right = cmd_bus.node_right;
    assign load_entry.leaf  = cmd_bus.node_is_leaf;
    assign load_entry.sym   = cmd_bus.node_symbol;
    assign tbl_we           = cmd_acc && (cmd_bus.command == CMD_LOAD);
    assign tbl_waddr        = wrap_index(cmd_bus.node_index);

    assign finished    = (emitted_reg >= expected_reg);
    assign emitted_inc = emitted_reg + 32'd1;
    assign bit_nxt     = bit_cnt_reg + BIT_CW'(1);
    assign leaf_hit    = (state_reg == ST_WALK) && walk_rdata.leaf;
    assign out_free    = !out_valid_reg || sym_bus.ready;
    assign stall       = leaf_hit && pend_valid_reg && !out_free;
    assign push_new    = leaf_hit && !stall;
    assign walk_entry  = walk_rdata.leaf ? root_rdata : walk_rdata;
    assign walk_node   = walk_rdata.leaf ? wrap_index(root_reg) : addr_reg;
    assign walk_last   = (bit_cnt_reg == BIT_CW'(BITS_PER_BYTE - 1))
                         || (walk_rdata.leaf && (emitted_inc == expected_reg));
    assign move_pend   = pend_valid_reg
                         && (push_new || ((state_reg == ST_FLUSH) && out_free));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc && (cmd_bus.command == CMD_DATA))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = finished ? ST_IDLE : ST_WALK;
            end
            ST_WALK:
            begin
                if (!stall && walk_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // table read address
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  rd_addr = cur_node_reg;
            ST_FETCH: rd_addr = child_of(walk_rdata, byte_reg[0]);
            ST_WALK:
            begin
                if (stall || walk_last)
                begin
                    rd_addr = addr_reg;
                end
                else
                begin
                    rd_addr = child_of(walk_entry, byte_reg[bit_nxt]);
                end
            end
            default:  rd_addr = addr_reg;
        endcase
    end

    // datapath and output stage
    always_comb
    begin
        root_next       = root_reg;
        expected_next   = expected_reg;
        cur_node_next   = cur_node_reg;
        emitted_next    = emitted_reg;
        byte_next       = byte_reg;
        bit_cnt_next    = bit_cnt_reg;
        addr_next       = addr_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;

        if (cfg_bus.valid && cfg_bus.ready)
        begin
            unique case (cfg_bus.index)
                CFG_ROOT_NODE:        root_next = cfg_bus.data[FIELD_IW-1:0];
                CFG_SYMBOLS_EXPECTED: expected_next = cfg_bus.data;
                default:              ;
            endcase
        end

        if (cmd_acc)
        begin
            unique case (cmd_bus.command)
                CMD_START:
                begin
                    cur_node_next = wrap_index(root_reg);
                    emitted_next  = 32'd0;
                end
                CMD_DATA:
                begin
                    byte_next    = cmd_bus.data_byte;
                    bit_cnt_next = '0;
                end
                default: ;
            endcase
        end

        if ((state_reg == ST_FETCH) || (state_reg == ST_WALK))
        begin
            addr_next = rd_addr;
        end

        if ((state_reg == ST_WALK) && !stall)
        begin
            cur_node_next = walk_node;
            bit_cnt_next  = bit_nxt;
        end

        if (sym_bus.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (move_pend)
        begin
            out_valid_next = 1'b1;
            out_sym_next   = pend_sym_reg;
            out_done_next  = pend_done_reg;
            out_last_next  = (state_reg == ST_FLUSH);
        end

        if ((state_reg == ST_FLUSH) && out_free)
        begin
            pend_valid_next = 1'b0;
        end

        if (push_new)
        begin
            emitted_next    = emitted_inc;
            pend_valid_next = 1'b1;
            pend_sym_next   = walk_rdata.sym;
            pend_done_next  = (emitted_inc == expected_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            root_reg       <= '0;
            expected_reg   <= '0;
            cur_node_reg   <= '0;
            emitted_reg    <= '0;
            bit_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            root_reg       <= root_next;
            expected_reg   <= expected_next;
            cur_node_reg   <= cur_node_next;
            emitted_reg    <= emitted_next;
            bit_cnt_reg    <= bit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        addr_reg      <= addr_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        out_sym_reg   <= out_sym_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    assign sym_bus.valid        = out_valid_reg;
    assign sym_bus.symbol       = out_sym_reg;
    assign sym_bus.last_of_item = out_last_reg;
    assign sym_bus.stream_done  = out_done_reg;

    a_emit_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        push_new |-> (emitted_reg < expected_reg))
        else $error("symbol emitted past expected count");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending symbol left behind at idle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        move_pend |-> (!out_valid_reg || sym_bus.ready))
        else $error("output register overwritten");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) && stall) |=>
            ((state_reg == ST_WALK) && $stable(addr_reg) && $stable(bit_cnt_reg)))
        else $error("walk advanced during output stall");

endmodule
